[rtl/pcd_pkg.sv]
// pcd_pkg: shared types, constants and tables of the png chunk deframer
// depends on nothing; every rtl file uses it through scoped names
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    // default depth of the word queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // reset value of the max_side register
    localparam logic [23:0] MAX_SIDE_RESET = 24'd1000000;

    // chunk walker phases
    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_DONE
    } t_phase;

    // final status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_SIG   = 4'd1;
    localparam logic [3:0] ST_TRUNC     = 4'd2;
    localparam logic [3:0] ST_BAD_IHDR  = 4'd3;
    localparam logic [3:0] ST_IDAT_EARLY = 4'd4;
    localparam logic [3:0] ST_MISSING   = 4'd5;
    localparam logic [3:0] ST_SIZE      = 4'd6;
    localparam logic [3:0] ST_METHOD    = 4'd7;
    localparam logic [3:0] ST_TYPE      = 4'd8;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // chunk type codes
    localparam logic [31:0] CHUNK_IHDR = 32'h49484452;
    localparam logic [31:0] CHUNK_IDAT = 32'h49444154;
    localparam logic [31:0] CHUNK_TRNS = 32'h74524E53;
    localparam logic [31:0] CHUNK_IEND = 32'h49454E44;

    // header and key layout
    localparam logic [31:0] IHDR_LEN     = 32'd13;
    localparam logic [31:0] TRNS_RGB_LEN = 32'd6;
    localparam logic [3:0]  IHDR_LAST_IDX = 4'd13;
    localparam logic [3:0]  WIDTH_END    = 4'd4;
    localparam logic [3:0]  HEIGHT_END   = 4'd8;
    localparam logic [3:0]  KEY_END      = 4'd6;
    localparam logic [7:0]  BIT_DEPTH_8  = 8'd8;
    localparam logic [7:0]  COLOR_RGB    = 8'd2;
    localparam logic [7:0]  COLOR_RGBA   = 8'd6;

    // one queued word: a payload byte or a status with its header snapshot
    typedef struct packed {
        logic        kind;
        logic [7:0]  pay;
        logic [3:0]  status;
        logic [23:0] width;
        logic [23:0] height;
        logic        rgba;
        logic        key_valid;
        logic [7:0]  key_red;
        logic [7:0]  key_green;
        logic [7:0]  key_blue;
    } t_entry;

    // png file signature
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd137;
            3'd1:    v = 8'd80;
            3'd2:    v = 8'd78;
            3'd3:    v = 8'd71;
            3'd4:    v = 8'd13;
            3'd5:    v = 8'd10;
            3'd6:    v = 8'd26;
            3'd7:    v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/pcd_front.sv]
// pcd_front: accepts file bytes, walks signature and chunks, classifies results
// depends on pcd_pkg; pushes words into pcd_queue
`timescale 1ns / 1ps
`default_nettype none

module pcd_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_file_byte,
    input  wire logic             i_file_last,
    output logic                  o_ready,
    input  wire logic             i_cfg_valid,
    input  wire logic [23:0]      i_cfg_max_side,
    input  wire logic             i_queue_full,
    output logic                  o_push,
    output pcd_pkg::t_entry       o_entry
);

    pcd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_fc, n_fc;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_len, n_len;
    logic [31:0] r_kind, n_kind;
    logic [3:0]  r_didx, n_didx;
    logic        r_key_capture, n_key_capture;
    logic        r_ihdr_seen, n_ihdr_seen;
    logic        r_idat_nonempty, n_idat_nonempty;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [7:0]  r_hdr [5];
    logic [7:0]  n_hdr [5];
    logic [7:0]  r_key [3];
    logic [7:0]  n_key [3];
    logic [7:0]  r_key_high, n_key_high;
    logic        r_key_valid, n_key_valid;
    logic        r_status_sent, n_status_sent;
    logic [23:0] r_max_side;

    logic        w_accept;
    logic        w_has_code;
    logic [3:0]  w_code;
    logic        w_pay;
    logic [3:0]  w_final;
    logic [31:0] w_kind_next;
    logic [31:0] w_max32;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_max32  = {8'd0, r_max_side};

    // max_side register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_side <= pcd_pkg::MAX_SIDE_RESET;
        end else if (i_cfg_valid) begin
            r_max_side <= i_cfg_max_side;
        end
    end

    // header validation at the end of iend
    always_comb begin
        if (!r_ihdr_seen || !r_idat_nonempty) begin
            w_final = pcd_pkg::ST_MISSING;
        end else if (r_width == 32'd0 || r_height == 32'd0
                     || r_width > w_max32 || r_height > w_max32) begin
            w_final = pcd_pkg::ST_SIZE;
        end else if (r_hdr[2] != 8'd0 || r_hdr[3] != 8'd0 || r_hdr[4] != 8'd0) begin
            w_final = pcd_pkg::ST_METHOD;
        end else if (r_hdr[0] != pcd_pkg::BIT_DEPTH_8
                     || (r_hdr[1] != pcd_pkg::COLOR_RGB
                         && r_hdr[1] != pcd_pkg::COLOR_RGBA)) begin
            w_final = pcd_pkg::ST_TYPE;
        end else begin
            w_final = pcd_pkg::ST_OK;
        end
    end

    // per-byte chunk walk
    always_comb begin
        n_phase         = r_phase;
        n_fc            = r_fc;
        n_rem           = r_rem;
        n_len           = r_len;
        n_kind          = r_kind;
        n_didx          = r_didx;
        n_key_capture   = r_key_capture;
        n_ihdr_seen     = r_ihdr_seen;
        n_idat_nonempty = r_idat_nonempty;
        n_width         = r_width;
        n_height        = r_height;
        n_hdr           = r_hdr;
        n_key           = r_key;
        n_key_high      = r_key_high;
        n_key_valid     = r_key_valid;
        n_status_sent   = r_status_sent;
        w_has_code      = 1'b0;
        w_code          = pcd_pkg::ST_OK;
        w_pay           = 1'b0;
        w_kind_next     = {r_kind[23:0], i_file_byte};

        case (r_phase)
            pcd_pkg::PH_SIG: begin
                if (i_file_byte != pcd_pkg::sig_byte(r_fc)) begin
                    w_has_code = 1'b1;
                    w_code     = pcd_pkg::ST_BAD_SIG;
                end else if (r_fc == 3'd7) begin
                    n_phase = pcd_pkg::PH_LEN;
                    n_fc    = 3'd0;
                    n_len   = 32'd0;
                end else begin
                    n_fc = r_fc + 3'd1;
                end
            end
            pcd_pkg::PH_LEN: begin
                n_len = {r_len[23:0], i_file_byte};
                if (r_fc == 3'd3) begin
                    n_phase = pcd_pkg::PH_TYPE;
                    n_fc    = 3'd0;
                    n_kind  = 32'd0;
                end else begin
                    n_fc = r_fc + 3'd1;
                end
            end
            pcd_pkg::PH_TYPE: begin
                n_kind = w_kind_next;
                if (r_fc == 3'd3) begin
                    n_fc          = 3'd0;
                    n_rem         = r_len;
                    n_didx        = 4'd0;
                    n_key_capture = (w_kind_next == pcd_pkg::CHUNK_TRNS)
                                    && (r_hdr[1] == pcd_pkg::COLOR_RGB)
                                    && (r_len >= pcd_pkg::TRNS_RGB_LEN);
                    n_phase       = (r_len != 32'd0) ? pcd_pkg::PH_DATA : pcd_pkg::PH_CRC;
                end else begin
                    n_fc = r_fc + 3'd1;
                end
            end
            pcd_pkg::PH_DATA: begin
                // header and key capture by data index
                if (r_kind == pcd_pkg::CHUNK_IHDR && r_didx < pcd_pkg::IHDR_LAST_IDX) begin
                    if (r_didx < pcd_pkg::WIDTH_END) begin
                        n_width = {r_width[23:0], i_file_byte};
                    end else if (r_didx < pcd_pkg::HEIGHT_END) begin
                        n_height = {r_height[23:0], i_file_byte};
                    end else begin
                        n_hdr[3'(r_didx - pcd_pkg::HEIGHT_END)] = i_file_byte;
                    end
                end else if (r_kind == pcd_pkg::CHUNK_TRNS && r_key_capture
                             && r_didx < pcd_pkg::KEY_END) begin
                    if (!r_didx[0]) begin
                        n_key_high = i_file_byte;
                    end else begin
                        n_key[r_didx[2:1]] = (r_key_high != 8'd0) ? r_key_high : i_file_byte;
                    end
                end
                w_pay  = (r_kind == pcd_pkg::CHUNK_IDAT);
                n_rem  = r_rem - 32'd1;
                n_didx = (r_didx == pcd_pkg::IHDR_LAST_IDX) ? r_didx : r_didx + 4'd1;
                if (r_rem == 32'd1) begin
                    n_phase = pcd_pkg::PH_CRC;
                    n_fc    = 3'd0;
                end
            end
            pcd_pkg::PH_CRC: begin
                n_fc = r_fc + 3'd1;
                if (r_fc == 3'd3) begin
                    // judge the finished chunk
                    if (r_kind == pcd_pkg::CHUNK_IHDR) begin
                        if (r_ihdr_seen || r_len != pcd_pkg::IHDR_LEN) begin
                            w_has_code = 1'b1;
                            w_code     = pcd_pkg::ST_BAD_IHDR;
                        end else begin
                            n_ihdr_seen = 1'b1;
                        end
                    end else if (r_kind == pcd_pkg::CHUNK_IDAT) begin
                        if (!r_ihdr_seen) begin
                            w_has_code = 1'b1;
                            w_code     = pcd_pkg::ST_IDAT_EARLY;
                        end else if (r_len != 32'd0) begin
                            n_idat_nonempty = 1'b1;
                        end
                    end else if (r_kind == pcd_pkg::CHUNK_TRNS) begin
                        if (r_key_capture) begin
                            n_key_valid = 1'b1;
                        end
                    end else if (r_kind == pcd_pkg::CHUNK_IEND) begin
                        w_has_code = 1'b1;
                        w_code     = w_final;
                    end
                    if (!w_has_code) begin
                        n_phase = pcd_pkg::PH_LEN;
                        n_fc    = 3'd0;
                        n_len   = 32'd0;
                        n_kind  = 32'd0;
                    end
                end
            end
            default: begin
            end
        endcase

        // file ends before iend completes
        if (i_file_last && !w_has_code && !r_status_sent) begin
            w_has_code = 1'b1;
            w_code     = (n_phase == pcd_pkg::PH_SIG) ? pcd_pkg::ST_BAD_SIG : pcd_pkg::ST_TRUNC;
        end

        if (w_has_code) begin
            n_phase       = pcd_pkg::PH_DONE;
            n_status_sent = 1'b1;
        end
    end

    // word toward the queue
    always_comb begin
        o_push            = w_accept && (w_has_code || w_pay);
        o_entry.kind      = w_has_code ? pcd_pkg::KIND_STATUS : pcd_pkg::KIND_PAYLOAD;
        o_entry.pay       = i_file_byte;
        o_entry.status    = w_code;
        o_entry.width     = r_width[23:0];
        o_entry.height    = r_height[23:0];
        o_entry.rgba      = (r_hdr[1] == pcd_pkg::COLOR_RGBA);
        o_entry.key_valid = r_key_valid;
        o_entry.key_red   = r_key[0];
        o_entry.key_green = r_key[1];
        o_entry.key_blue  = r_key[2];
    end

    // walker state, cleared by reset and at the final byte of each file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_file_last)) begin
            r_phase         <= pcd_pkg::PH_SIG;
            r_fc            <= 3'd0;
            r_rem           <= 32'd0;
            r_len           <= 32'd0;
            r_kind          <= 32'd0;
            r_didx          <= 4'd0;
            r_key_capture   <= 1'b0;
            r_ihdr_seen     <= 1'b0;
            r_idat_nonempty <= 1'b0;
            r_width         <= 32'd0;
            r_height        <= 32'd0;
            r_hdr           <= '{default: 8'd0};
            r_key           <= '{default: 8'd0};
            r_key_high      <= 8'd0;
            r_key_valid     <= 1'b0;
            r_status_sent   <= 1'b0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_fc            <= n_fc;
            r_rem           <= n_rem;
            r_len           <= n_len;
            r_kind          <= n_kind;
            r_didx          <= n_didx;
            r_key_capture   <= n_key_capture;
            r_ihdr_seen     <= n_ihdr_seen;
            r_idat_nonempty <= n_idat_nonempty;
            r_width         <= n_width;
            r_height        <= n_height;
            r_hdr           <= n_hdr;
            r_key           <= n_key;
            r_key_high      <= n_key_high;
            r_key_valid     <= n_key_valid;
            r_status_sent   <= n_status_sent;
        end
    end

`ifndef SYNTHESIS
    // a sent status parks the walker until the file ends
    a_sent_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status_sent |-> (r_phase == pcd_pkg::PH_DONE))
        else $error("status sent but walker not parked");

    // data phase always has bytes left
    a_data_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcd_pkg::PH_DATA) |-> (r_rem != 32'd0))
        else $error("data phase with no bytes left");

    // field counters of four-byte fields stay below four
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcd_pkg::PH_LEN || r_phase == pcd_pkg::PH_TYPE
         || r_phase == pcd_pkg::PH_CRC) |-> (r_fc < 3'd4))
        else $error("field counter out of range");
`endif

endmodule

`default_nettype wire

[rtl/pcd_queue.sv]
// pcd_queue: short word queue that decouples the chunk walker from the output side
// depends on pcd_pkg for the word type
`timescale 1ns / 1ps
`default_nettype none

module pcd_queue #(
    parameter int unsigned DEPTH = pcd_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire pcd_pkg::t_entry  i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output pcd_pkg::t_entry       o_entry,
    input  wire logic             i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    pcd_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    // pointer wrap
    always_comb begin
        n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    // the walker never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    // the output side never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    // fill count advances on a push without a pop
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("fill count did not advance");
`endif

endmodule

`default_nettype wire

[rtl/pcd_back.sv]
// pcd_back: output register that formats queued words into result fields
// depends on pcd_pkg; pops words from pcd_queue
`timescale 1ns / 1ps
`default_nettype none

module pcd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire pcd_pkg::t_entry  i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_result_kind,
    output logic [7:0]            o_payload_byte,
    output logic [3:0]            o_status,
    output logic [23:0]           o_image_width,
    output logic [23:0]           o_image_height,
    output logic                  o_alpha_flag,
    output logic                  o_rgba_source,
    output logic                  o_key_present,
    output logic [7:0]            o_key_red,
    output logic [7:0]            o_key_green,
    output logic [7:0]            o_key_blue,
    output logic                  o_last
);

    logic r_valid;
    logic w_status;
    logic w_ok;
    logic w_key;

    assign o_valid  = r_valid;
    assign o_q_pop  = i_q_valid && (!r_valid || i_ready);
    assign w_status = (i_q_entry.kind == pcd_pkg::KIND_STATUS);
    assign w_ok     = w_status && (i_q_entry.status == pcd_pkg::ST_OK);
    assign w_key    = w_ok && i_q_entry.key_valid;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_q_valid;
        end
    end

    // result fields, zeroed where the word kind or status leaves them unused
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_result_kind  <= i_q_entry.kind;
            o_payload_byte <= w_status ? 8'd0 : i_q_entry.pay;
            o_status       <= w_status ? i_q_entry.status : pcd_pkg::ST_OK;
            o_image_width  <= w_ok ? i_q_entry.width : 24'd0;
            o_image_height <= w_ok ? i_q_entry.height : 24'd0;
            o_alpha_flag   <= w_ok && (i_q_entry.rgba || i_q_entry.key_valid);
            o_rgba_source  <= w_ok && i_q_entry.rgba;
            o_key_present  <= w_key;
            o_key_red      <= w_key ? i_q_entry.key_red : 8'd0;
            o_key_green    <= w_key ? i_q_entry.key_green : 8'd0;
            o_key_blue     <= w_key ? i_q_entry.key_blue : 8'd0;
            o_last         <= w_status;
        end
    end

endmodule

`default_nettype wire

[rtl/png_chunk_deframer_unit.sv]
// png_chunk_deframer_unit: top level joining chunk walker, word queue and output register
// depends on pcd_pkg, pcd_front, pcd_queue, pcd_back
// path: each result is registered in the word queue, then in the output register
// throughput: one file byte per cycle while o_ready is high; the walker updates all chunk state per byte
// o_ready drops only while the word queue is full behind a stalled output
// reset: synchronous active-low i_rst_n clears walker, queue and output valid, max_side to 1000000
`timescale 1ns / 1ps
`default_nettype none

module png_chunk_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = pcd_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_file_byte,
    input  wire logic             i_file_last,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [23:0]      i_cfg_max_side,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_result_kind,
    output logic [7:0]            o_payload_byte,
    output logic [3:0]            o_status,
    output logic [23:0]           o_image_width,
    output logic [23:0]           o_image_height,
    output logic                  o_alpha_flag,
    output logic                  o_rgba_source,
    output logic                  o_key_present,
    output logic [7:0]            o_key_red,
    output logic [7:0]            o_key_green,
    output logic [7:0]            o_key_blue,
    output logic                  o_last
);

    logic            w_push;
    logic            w_full;
    logic            w_q_valid;
    logic            w_pop;
    pcd_pkg::t_entry w_push_entry;
    pcd_pkg::t_entry w_head_entry;

    // configuration writes must happen only while idle; the block itself does not enforce it
    assign o_cfg_ready = 1'b1;

    // chunk walker
    pcd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_file_byte    (i_file_byte),
        .i_file_last    (i_file_last),
        .o_ready        (o_ready),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_max_side (i_cfg_max_side),
        .i_queue_full   (w_full),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    // word queue
    pcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry),
        .i_pop   (w_pop)
    );

    // output register
    pcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_entry      (w_head_entry),
        .o_q_pop        (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_alpha_flag   (o_alpha_flag),
        .o_rgba_source  (o_rgba_source),
        .o_key_present  (o_key_present),
        .o_key_red      (o_key_red),
        .o_key_green    (o_key_green),
        .o_key_blue     (o_key_blue),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// tb: self-checking bench for png_chunk_deframer_unit, byte stream in, words out
// depends on rtl/pcd_pkg.sv and rtl/png_chunk_deframer_unit.sv; an in-bench chunk walker
// predicts each word not given by a typed directed row, random png-like files with stalls on both sides drive the block
`timescale 1ns / 1ps

module tb;
    import pcd_pkg::*;

    localparam int ITEMS_PER_PHASE = 370;
    localparam int N_PHASES        = 5;
    localparam int N_DIRECTED      = 27;
    localparam int SETTLE_CYCLES   = 5;
    localparam int DRAIN_CYCLES    = 20;
    localparam int OUT_HOLD_CYCLES = 300;

    localparam logic [7:0] PNG_MAGIC [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                              8'd13, 8'd10, 8'd26, 8'd10};

    // one output word as the block should present it
    typedef struct packed {
        logic        kind;
        logic [7:0]  pay;
        logic [3:0]  status;
        logic [23:0] width;
        logic [23:0] height;
        logic        alpha;
        logic        rgba;
        logic        key_on;
        logic [7:0]  key_r;
        logic [7:0]  key_g;
        logic [7:0]  key_b;
        logic        last;
    } t_outword;

    // directed stimulus row; typed rows carry their status code directly
    typedef struct packed {
        logic [7:0] b;
        logic       eof;
        logic       typed;
        logic [3:0] code;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_file_byte;
    logic        i_file_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_max_side;
    logic        o_valid;
    logic        i_ready;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_status;
    logic [23:0] o_image_width;
    logic [23:0] o_image_height;
    logic        o_alpha_flag;
    logic        o_rgba_source;
    logic        o_key_present;
    logic [7:0]  o_key_red;
    logic [7:0]  o_key_green;
    logic [7:0]  o_key_blue;
    logic        o_last;

    png_chunk_deframer_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_file_byte    (i_file_byte),
        .i_file_last    (i_file_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_max_side (i_cfg_max_side),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_alpha_flag   (o_alpha_flag),
        .o_rgba_source  (o_rgba_source),
        .o_key_present  (o_key_present),
        .o_key_red      (o_key_red),
        .o_key_green    (o_key_green),
        .o_key_blue     (o_key_blue),
        .o_last         (o_last)
    );

    // bench state shared by processes
    t_outword   pending_words[$];
    logic [7:0] file_q[$];
    logic [7:0] body_q[$];
    t_dir_row   dir_rows [N_DIRECTED];
    int         mismatches;
    int         phase_items;
    bit         send_idle;
    bit         recv_idle;
    bit         out_hold_req;

    // chunk walker state, mirrors the block
    logic [23:0] max_side_cfg;
    t_phase      walk_phase;
    logic [2:0]  fld_cnt;
    logic [31:0] bytes_left;
    logic [31:0] chunk_len;
    logic [31:0] chunk_code;
    logic        grab_key;
    logic        hdr_seen;
    logic        idat_data_seen;
    logic [31:0] hdr_w;
    logic [31:0] hdr_h;
    logic [7:0]  hdr_misc [5];
    logic [7:0]  key_val [3];
    logic [7:0]  key_msb;
    logic        key_ok;
    logic        done_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // per-file walker state back to the signature phase
    function automatic void clear_walker();
        walk_phase     = PH_SIG;
        fld_cnt        = '0;
        bytes_left     = '0;
        chunk_len      = '0;
        chunk_code     = '0;
        grab_key       = 1'b0;
        hdr_seen       = 1'b0;
        idat_data_seen = 1'b0;
        hdr_w          = '0;
        hdr_h          = '0;
        foreach (hdr_misc[i]) hdr_misc[i] = '0;
        foreach (key_val[i]) key_val[i] = '0;
        key_msb        = '0;
        key_ok         = 1'b0;
        done_sent      = 1'b0;
    endfunction

    // header checks made at the end of iend
    function automatic logic [3:0] header_verdict();
        if (!hdr_seen || !idat_data_seen)
            return ST_MISSING;
        if (hdr_w == 0 || hdr_h == 0 || hdr_w > {8'd0, max_side_cfg} ||
            hdr_h > {8'd0, max_side_cfg})
            return ST_SIZE;
        if (hdr_misc[2] != 0 || hdr_misc[3] != 0 || hdr_misc[4] != 0)
            return ST_METHOD;
        if (hdr_misc[0] != BIT_DEPTH_8 ||
            (hdr_misc[1] != COLOR_RGB && hdr_misc[1] != COLOR_RGBA))
            return ST_TYPE;
        return ST_OK;
    endfunction

    // judge a finished chunk; returns 1 when it ends the file with a status
    function automatic bit close_chunk(output logic [3:0] code);
        code = ST_OK;
        if (chunk_code == CHUNK_IHDR) begin
            if (hdr_seen || chunk_len != IHDR_LEN) begin
                code = ST_BAD_IHDR;
                return 1'b1;
            end
            hdr_seen = 1'b1;
        end else if (chunk_code == CHUNK_IDAT) begin
            if (!hdr_seen) begin
                code = ST_IDAT_EARLY;
                return 1'b1;
            end
            if (chunk_len != 0)
                idat_data_seen = 1'b1;
        end else if (chunk_code == CHUNK_TRNS) begin
            if (grab_key)
                key_ok = 1'b1;
        end else if (chunk_code == CHUNK_IEND) begin
            code = header_verdict();
            return 1'b1;
        end
        walk_phase = PH_LEN;
        fld_cnt    = '0;
        chunk_len  = '0;
        chunk_code = '0;
        return 1'b0;
    endfunction

    // header and key capture from chunk data
    function automatic void absorb_data(input logic [7:0] b);
        logic [31:0] idx;
        idx = chunk_len - bytes_left;
        if (chunk_code == CHUNK_IHDR && idx < IHDR_LAST_IDX) begin
            if (idx < WIDTH_END)
                hdr_w = {hdr_w[23:0], b};
            else if (idx < HEIGHT_END)
                hdr_h = {hdr_h[23:0], b};
            else
                hdr_misc[3'(idx - HEIGHT_END)] = b;
        end else if (chunk_code == CHUNK_TRNS && grab_key && idx < KEY_END) begin
            // 16-bit component: a nonzero high byte stands for the whole value
            if (!idx[0])
                key_msb = b;
            else
                key_val[idx[2:1]] = (key_msb != 0) ? key_msb : b;
        end
    endfunction

    // one accepted file byte through the walker; at most one word comes out
    function automatic void walk_byte(input logic [7:0] b, input logic eof,
                                      output bit has, output t_outword w);
        bit         stat;
        bit         fwd;
        logic [3:0] code;
        stat = 1'b0;
        fwd  = 1'b0;
        code = ST_OK;
        case (walk_phase)
            PH_SIG: begin
                if (b != PNG_MAGIC[fld_cnt]) begin
                    stat = 1'b1;
                    code = ST_BAD_SIG;
                end else if (fld_cnt >= 7) begin
                    walk_phase = PH_LEN;
                    fld_cnt    = '0;
                    chunk_len  = '0;
                end else begin
                    fld_cnt = fld_cnt + 1'b1;
                end
            end
            PH_LEN: begin
                chunk_len = {chunk_len[23:0], b};
                fld_cnt   = fld_cnt + 1'b1;
                if (fld_cnt >= 4) begin
                    walk_phase = PH_TYPE;
                    fld_cnt    = '0;
                    chunk_code = '0;
                end
            end
            PH_TYPE: begin
                chunk_code = {chunk_code[23:0], b};
                fld_cnt    = fld_cnt + 1'b1;
                if (fld_cnt >= 4) begin
                    fld_cnt    = '0;
                    bytes_left = chunk_len;
                    grab_key   = chunk_code == CHUNK_TRNS && hdr_misc[1] == COLOR_RGB &&
                                 chunk_len >= TRNS_RGB_LEN;
                    walk_phase = (chunk_len != 0) ? PH_DATA : PH_CRC;
                end
            end
            PH_DATA: begin
                absorb_data(b);
                fwd        = chunk_code == CHUNK_IDAT;
                bytes_left = bytes_left - 1;
                if (bytes_left == 0) begin
                    walk_phase = PH_CRC;
                    fld_cnt    = '0;
                end
            end
            PH_CRC: begin
                fld_cnt = fld_cnt + 1'b1;
                if (fld_cnt >= 4)
                    stat = close_chunk(code);
            end
            default: ;
        endcase

        // file ended before a status went out
        if (eof && !stat && !done_sent) begin
            stat = 1'b1;
            code = (walk_phase == PH_SIG) ? ST_BAD_SIG : ST_TRUNC;
        end

        w   = '0;
        has = stat || fwd;
        if (stat) begin
            w.kind   = KIND_STATUS;
            w.status = code;
            if (code == ST_OK) begin
                w.width  = hdr_w[23:0];
                w.height = hdr_h[23:0];
                w.rgba   = hdr_misc[1] == COLOR_RGBA;
                w.alpha  = w.rgba || key_ok;
                if (key_ok) begin
                    w.key_on = 1'b1;
                    w.key_r  = key_val[0];
                    w.key_g  = key_val[1];
                    w.key_b  = key_val[2];
                end
            end
            w.last = 1'b1;
        end else if (fwd) begin
            w.kind = KIND_PAYLOAD;
            w.pay  = b;
        end

        if (eof) begin
            clear_walker();
        end else if (stat) begin
            walk_phase = PH_DONE;
            done_sent  = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // file building helpers
    function automatic void put_word(input logic [31:0] v);
        file_q.push_back(v[31:24]);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[7:0]);
    endfunction

    function automatic void put_body_word(input logic [31:0] v);
        body_q.push_back(v[31:24]);
        body_q.push_back(v[23:16]);
        body_q.push_back(v[15:8]);
        body_q.push_back(v[7:0]);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // length, type, body from body_q, then a crc that nobody checks
    function automatic void put_chunk(input logic [31:0] kind);
        put_word(32'(body_q.size()));
        put_word(kind);
        foreach (body_q[i]) file_q.push_back(body_q[i]);
        repeat (4) file_q.push_back(rand_byte());
    endfunction

    // image side: mostly small, with zero and both sides of the limit
    function automatic logic [31:0] pick_side();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return 32'd0;
        if (r < 16) return 32'd1;
        if (r < 26) return {8'd0, max_side_cfg};
        if (r < 34) return {8'd0, max_side_cfg} + 32'd1;
        if (r < 38) return $urandom;
        return $urandom_range(1, 300);
    endfunction

    function automatic void add_ihdr(output logic [7:0] color);
        int r;
        body_q.delete();
        put_body_word(pick_side());
        put_body_word(pick_side());
        r     = $urandom_range(0, 99);
        color = (r < 45) ? COLOR_RGB : (r < 90) ? COLOR_RGBA : rand_byte();
        body_q.push_back(($urandom_range(0, 99) < 90) ? BIT_DEPTH_8 : rand_byte());
        body_q.push_back(color);
        repeat (3) body_q.push_back(($urandom_range(0, 99) < 95) ? 8'd0 : rand_byte());
        // wrong header length now and then
        r = $urandom_range(0, 99);
        if (r < 5)
            void'(body_q.pop_back());
        else if (r < 9)
            body_q.push_back(rand_byte());
        put_chunk(CHUNK_IHDR);
    endfunction

    function automatic void add_idat();
        int n;
        body_q.delete();
        n = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 6);
        repeat (n) body_q.push_back(rand_byte());
        put_chunk(CHUNK_IDAT);
    endfunction

    function automatic void add_trns();
        int r;
        int n;
        body_q.delete();
        r = $urandom_range(0, 99);
        n = (r < 60) ? 6 : (r < 80) ? 8 : (r < 90) ? 4 : 2;
        for (int i = 0; i < n; i++)
            body_q.push_back((!i[0] && $urandom_range(0, 1)) ? 8'd0 : rand_byte());
        put_chunk(CHUNK_TRNS);
    endfunction

    function automatic void add_unknown();
        int n;
        body_q.delete();
        n = $urandom_range(0, 5);
        repeat (n) body_q.push_back(rand_byte());
        put_chunk($urandom);
    endfunction

    // one random file into file_q: mostly well formed, some broken, some noise
    function automatic void build_file();
        int         r;
        int         n;
        logic [7:0] color;
        file_q.delete();
        color = '0;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            n = $urandom_range(1, 24);
            repeat (n) file_q.push_back(rand_byte());
            return;
        end
        foreach (PNG_MAGIC[i]) file_q.push_back(PNG_MAGIC[i]);
        if (r < 12)
            file_q[$urandom_range(0, 7)] = rand_byte();
        if ($urandom_range(0, 99) < 4)
            add_idat();
        if ($urandom_range(0, 99) < 96)
            add_ihdr(color);
        if ($urandom_range(0, 99) < 3)
            add_ihdr(color);
        if (color == COLOR_RGB && $urandom_range(0, 1))
            add_trns();
        n = $urandom_range(1, 3);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 65)
                add_idat();
            else if (r < 80)
                add_trns();
            else
                add_unknown();
        end
        r = $urandom_range(0, 99);
        // huge length, counted down until the file runs out
        if (r < 3) begin
            put_word({8'hFF, 24'($urandom)});
            put_word($urandom);
            n = $urandom_range(0, 6);
            repeat (n) file_q.push_back(rand_byte());
            return;
        end
        // ends right after a complete chunk that is not iend
        if (r < 8)
            return;
        body_q.delete();
        if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(1, 3);
            repeat (n) body_q.push_back(rand_byte());
        end
        put_chunk(CHUNK_IEND);
        // trailing bytes after iend
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 4);
            repeat (n) file_q.push_back(rand_byte());
        end
        // cut short anywhere
        if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(1, file_q.size());
            while (file_q.size() > n)
                void'(file_q.pop_back());
        end
    endfunction

    // offer one file byte, wait for it to be taken, then predict what it causes
    task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                             input logic [3:0] code);
        int       gap;
        bit       has;
        t_outword w;
        gap = (send_idle && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_file_byte <= b;
        i_file_last <= eof;
        do @(posedge i_clk); while (!o_ready);
        walk_byte(b, eof, has, w);
        if (typed) begin
            w        = '0;
            w.kind   = KIND_STATUS;
            w.status = code;
            w.last   = 1'b1;
            has      = 1'b1;
        end
        if (has)
            pending_words.push_back(w);
        phase_items++;
    endtask

    task automatic write_max_side(input logic [23:0] v);
        i_cfg_valid    <= 1'b1;
        i_cfg_max_side <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_side_cfg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_ready
        int n;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (out_hold_req) begin
                out_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge i_clk);
            end else if (recv_idle && $urandom_range(0, 3) == 0) begin
                n = gap_len();
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_outword want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t ns: word with nothing expected, expected none, got kind %0d status %0d",
                         $time, o_result_kind, o_status);
            end else begin
                want = pending_words.pop_front();
                check_field("result_kind", want.kind, o_result_kind);
                check_field("payload_byte", want.pay, o_payload_byte);
                check_field("status", want.status, o_status);
                check_field("image_width", want.width, o_image_width);
                check_field("image_height", want.height, o_image_height);
                check_field("alpha_flag", want.alpha, o_alpha_flag);
                check_field("rgba_source", want.rgba, o_rgba_source);
                check_field("key_present", want.key_on, o_key_present);
                check_field("key_red", want.key_r, o_key_red);
                check_field("key_green", want.key_g, o_key_green);
                check_field("key_blue", want.key_b, o_key_blue);
                check_field("last", want.last, o_last);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int p;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_file_byte    = '0;
        i_file_last    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_max_side = '0;
        mismatches     = 0;
        phase_items    = 0;
        send_idle      = 1'b1;
        recv_idle      = 1'b1;
        out_hold_req   = 1'b0;
        max_side_cfg   = MAX_SIDE_RESET;
        clear_walker();

        // wrong first byte that is also the last one
        dir_rows[0]  = '{8'd0, 1'b1, 1'b1, ST_BAD_SIG};
        // file ends inside the signature
        dir_rows[1]  = '{PNG_MAGIC[0], 1'b0, 1'b0, ST_OK};
        dir_rows[2]  = '{PNG_MAGIC[1], 1'b1, 1'b1, ST_BAD_SIG};
        // mismatch mid-signature, then bytes ignored until the file ends
        dir_rows[3]  = '{PNG_MAGIC[0], 1'b0, 1'b0, ST_OK};
        dir_rows[4]  = '{8'd255, 1'b0, 1'b1, ST_BAD_SIG};
        dir_rows[5]  = '{8'd0, 1'b1, 1'b0, ST_OK};
        // bare signature plus empty iend: no header, no image data
        for (int i = 0; i < 8; i++)
            dir_rows[6 + i] = '{PNG_MAGIC[i], 1'b0, 1'b0, ST_OK};
        for (int i = 0; i < 4; i++)
            dir_rows[14 + i] = '{8'd0, 1'b0, 1'b0, ST_OK};
        dir_rows[18] = '{CHUNK_IEND[31:24], 1'b0, 1'b0, ST_OK};
        dir_rows[19] = '{CHUNK_IEND[23:16], 1'b0, 1'b0, ST_OK};
        dir_rows[20] = '{CHUNK_IEND[15:8], 1'b0, 1'b0, ST_OK};
        dir_rows[21] = '{CHUNK_IEND[7:0], 1'b0, 1'b0, ST_OK};
        for (int i = 0; i < 3; i++)
            dir_rows[22 + i] = '{8'd255, 1'b0, 1'b0, ST_OK};
        dir_rows[25] = '{8'd255, 1'b0, 1'b1, ST_MISSING};
        // byte after iend is ignored, closes the file
        dir_rows[26] = '{8'hAA, 1'b1, 1'b0, ST_OK};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].eof, dir_rows[i].typed, dir_rows[i].code);

        // random files over several max_side settings
        for (p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                i_valid <= 1'b0;
                while (pending_words.size() != 0) @(posedge i_clk);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                case (p)
                    1:       write_max_side(24'd1);
                    2:       write_max_side(24'hFFFFFF);
                    3:       write_max_side(24'($urandom_range(2, 300)));
                    default: write_max_side(24'($urandom_range(301, 1000000)));
                endcase
            end
            send_idle = (p != 1);
            recv_idle = (p != 1);
            if (p == 2)
                out_hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                build_file();
                for (int k = 0; k < file_q.size(); k++)
                    send_byte(file_q[k], k == file_q.size() - 1, 1'b0, ST_OK);
            end
        end

        // drain and finish
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
